/* hdl/aarm_pkg.sv */
// Package: shared types and constants for the axis-angle rotation matrix block.
`timescale 1ns / 1ps
package aarm_pkg;
	localparam int ATAN_COUNT = 24;
	localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;

	// atan(2^-i) in 2^32-per-turn units
	function automatic logic signed [33:0] atan_turn(input int i);
		logic signed [33:0] r;
		begin
			case (i)
				0: r = 34'sh20000000;
				1: r = 34'sh12E4051E;
				2: r = 34'sh09FB385B;
				3: r = 34'sh051111D4;
				4: r = 34'sh028B0D43;
				5: r = 34'sh0145D7E1;
				6: r = 34'sh00A2F61E;
				7: r = 34'sh00517C55;
				8: r = 34'sh0028BE53;
				9: r = 34'sh00145F2F;
				10: r = 34'sh000A2F98;
				11: r = 34'sh000517CC;
				12: r = 34'sh00028BE6;
				13: r = 34'sh000145F3;
				14: r = 34'sh0000A2FA;
				15: r = 34'sh0000517D;
				16: r = 34'sh000028BE;
				17: r = 34'sh0000145F;
				18: r = 34'sh00000A30;
				19: r = 34'sh00000518;
				20: r = 34'sh0000028C;
				21: r = 34'sh00000146;
				22: r = 34'sh000000A3;
				23: r = 34'sh00000051;
				default: r = '0;
			endcase
			return r;
		end
	endfunction

	// per-stage pipeline control
	typedef struct packed {
		logic valid;
		logic enable;
	} stage_ctl_t;
endpackage

/* hdl/axis_angle_rotation_matrix.sv */
// Top level: stream wrapper around the CORDIC and matrix pipelines.
// Path: the CORDIC pipeline and then the matrix pipeline, every stage registered.
// Throughput: one item per cycle while the output is not stalled; the whole pipeline advances together.
// Stall: when the output holds an unaccepted item, every stage freezes.
// Reset: arst_n clears all valid bits at once; no clearing pass.
`timescale 1ns / 1ps
module axis_angle_rotation_matrix import aarm_pkg::*; #(
	parameter int CORDIC_STEPS = 16,
	parameter int FRAC_BITS = 14
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [63:0]  s_axis_tdata,  // turn_angle, axis_x, axis_y, axis_z
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [159:0] m_axis_tdata   // r00 r01 r02 r10 r11 r12 r20 r21 r22, zero pad
);
	logic enable;
	logic cv;
	logic signed [FRAC_BITS+2:0] c, s;
	logic [47:0] tag;
	logic [152:0] mat;

	// output register moves when empty or taken
	assign enable = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = enable;

	aarm_cordic #(.STEPS(CORDIC_STEPS), .FRAC_BITS(FRAC_BITS), .TAG_W(48)) u_cordic (
		.clk(clk), .arst_n(arst_n), .enable(enable),
		.in_valid(s_axis_tvalid),
		.angle(s_axis_tdata[15:0]),
		.tag_in(s_axis_tdata[63:16]),
		.out_valid(cv), .cos_out(c), .sin_out(s), .tag_out(tag)
	);

	aarm_matrix #(.FRAC_BITS(FRAC_BITS)) u_matrix (
		.clk(clk), .arst_n(arst_n), .enable(enable),
		.in_valid(cv), .c_in(c), .s_in(s),
		.ux(tag[15:0]), .uy(tag[31:16]), .uz(tag[47:32]),
		.out_valid(m_axis_tvalid), .mat(mat)
	);

	assign m_axis_tdata = {7'd0, mat};

	// stalled result must hold
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed under stall");
	// ready follows the output register
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input blocked with empty output");
	// CORDIC output cannot be valid while frozen and lost
	a_cv: assert property (@(posedge clk) disable iff (!arst_n)
		cv && !enable |=> cv)
		else $error("stage valid dropped during stall");
endmodule

/* hdl/aarm_cordic.sv */
// Unrolled, one-stage-per-step CORDIC giving cosine and sine of a binary angle.
`timescale 1ns / 1ps
module aarm_cordic import aarm_pkg::*; #(
	parameter int STEPS = 16,
	parameter int FRAC_BITS = 14,
	parameter int TAG_W = 48
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        enable,
	input  logic                        in_valid,
	input  logic signed [15:0]          angle,
	input  logic [TAG_W-1:0]            tag_in,
	output logic                        out_valid,
	output logic signed [FRAC_BITS+2:0] cos_out,
	output logic signed [FRAC_BITS+2:0] sin_out,
	output logic [TAG_W-1:0]            tag_out
);
	localparam int N = (STEPS < ATAN_COUNT) ? STEPS : ATAN_COUNT;
	localparam int SH = 30 - FRAC_BITS;

	logic signed [33:0] x_q [0:N];
	logic signed [33:0] y_q [0:N];
	logic signed [33:0] z_q [0:N];
	logic               f_q [0:N];
	logic               v_q [0:N];
	logic [TAG_W-1:0]   t_q [0:N];

	logic signed [33:0] z0;
	logic               flip0;

	// range reduction to +/- quarter turn
	always_comb begin
		z0 = {{2{angle[15]}}, angle, 16'd0};
		flip0 = 1'b0;
		if (z0 > 34'sh40000000) begin
			z0 = z0 - 34'sh80000000;
			flip0 = 1'b1;
		end else if (z0 < -34'sh40000000) begin
			z0 = z0 + 34'sh80000000;
			flip0 = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q[0] <= 1'b0;
		end else if (enable) begin
			v_q[0] <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (enable) begin
			x_q[0] <= GAIN_Q30;
			y_q[0] <= '0;
			z_q[0] <= z0;
			f_q[0] <= flip0;
			t_q[0] <= tag_in;
		end
	end

	// rotation stages
	for (genvar i = 0; i < N; i++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[i+1] <= 1'b0;
			end else if (enable) begin
				v_q[i+1] <= v_q[i];
			end
		end
		always_ff @(posedge clk) begin
			if (enable) begin
				if (!z_q[i][33]) begin
					x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] - atan_turn(i);
				end else begin
					x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] + atan_turn(i);
				end
				f_q[i+1] <= f_q[i];
				t_q[i+1] <= t_q[i];
			end
		end
	end

	// sign fix and rounding to output fraction bits
	logic signed [33:0] xf, yf, xr, yr;
	always_comb begin
		xf = f_q[N] ? -x_q[N] : x_q[N];
		yf = f_q[N] ? -y_q[N] : y_q[N];
		xr = (xf + (34'sd1 <<< (SH - 1))) >>> SH;
		yr = (yf + (34'sd1 <<< (SH - 1))) >>> SH;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (enable) begin
			out_valid <= v_q[N];
		end
	end
	always_ff @(posedge clk) begin
		if (enable) begin
			cos_out <= xr[FRAC_BITS+2:0];
			sin_out <= yr[FRAC_BITS+2:0];
			tag_out <= t_q[N];
		end
	end
endmodule

/* hdl/aarm_matrix.sv */
// Rodrigues combination: products, second products and saturated sums, three stages.
`timescale 1ns / 1ps
module aarm_matrix import aarm_pkg::*; #(
	parameter int FRAC_BITS = 14
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        enable,
	input  logic                        in_valid,
	input  logic signed [FRAC_BITS+2:0] c_in,
	input  logic signed [FRAC_BITS+2:0] s_in,
	input  logic signed [15:0]          ux,
	input  logic signed [15:0]          uy,
	input  logic signed [15:0]          uz,
	output logic                        out_valid,
	output logic [152:0]                mat
);
	localparam int CW = FRAC_BITS + 3;
	// 1 - c spans [0, 2.0]
	localparam int OW = CW + 1;
	// axis products and 1 - u*u: the larger of 2^FRAC_BITS and 2^(30-FRAC_BITS), signed
	localparam int PW = ((FRAC_BITS > 15) ? FRAC_BITS : 30 - FRAC_BITS) + 3;
	localparam logic signed [47:0] ONE = 48'sd1 <<< FRAC_BITS;
	localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

	function automatic logic signed [47:0] rnd(input logic signed [63:0] p);
		logic signed [63:0] r;
		begin
			r = (p + HALF) >>> FRAC_BITS;
			return r[47:0];
		end
	endfunction

	function automatic logic [16:0] sat(input logic signed [47:0] v);
		logic [16:0] r;
		begin
			if (v > 48'sd65535) r = 17'h0FFFF;
			else if (v < -48'sd65536) r = 17'h10000;
			else r = v[16:0];
			return r;
		end
	endfunction

	stage_ctl_t ctl;
	assign ctl.enable = enable;
	assign ctl.valid = in_valid;

	// stage 1: axis products
	logic signed [PW-1:0] xx_s1, yy_s1, zz_s1, xy_s1, yz_s1, zx_s1;
	logic signed [CW-1:0] c_s1, s_s1;
	logic signed [15:0] ux_s1, uy_s1, uz_s1;
	logic v_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (ctl.enable) v_s1 <= ctl.valid;
	end
	always_ff @(posedge clk) begin
		if (ctl.enable) begin
			xx_s1 <= PW'(rnd(64'(ux * ux)));
			yy_s1 <= PW'(rnd(64'(uy * uy)));
			zz_s1 <= PW'(rnd(64'(uz * uz)));
			xy_s1 <= PW'(rnd(64'(ux * uy)));
			yz_s1 <= PW'(rnd(64'(uy * uz)));
			zx_s1 <= PW'(rnd(64'(uz * ux)));
			c_s1 <= c_in;
			s_s1 <= s_in;
			ux_s1 <= ux;
			uy_s1 <= uy;
			uz_s1 <= uz;
		end
	end

	// stage 2: products with c, s and 1-c
	logic signed [OW-1:0] omc;
	logic signed [PW-1:0] ex, ey, ez;
	assign omc = OW'(ONE - 48'(c_s1));
	assign ex = PW'(ONE - 48'(xx_s1));
	assign ey = PW'(ONE - 48'(yy_s1));
	assign ez = PW'(ONE - 48'(zz_s1));
	logic signed [47:0] dx_s2, dy_s2, dz_s2;
	logic signed [PW-1:0] xx_s2, yy_s2, zz_s2;
	logic signed [47:0] txy_s2, tyz_s2, tzx_s2, xs_s2, ys_s2, zs_s2;
	logic v_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (ctl.enable) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (ctl.enable) begin
			dx_s2 <= rnd(64'(c_s1 * ex));
			dy_s2 <= rnd(64'(c_s1 * ey));
			dz_s2 <= rnd(64'(c_s1 * ez));
			xx_s2 <= xx_s1;
			yy_s2 <= yy_s1;
			zz_s2 <= zz_s1;
			txy_s2 <= rnd(64'(xy_s1 * omc));
			tyz_s2 <= rnd(64'(yz_s1 * omc));
			tzx_s2 <= rnd(64'(zx_s1 * omc));
			xs_s2 <= rnd(64'(ux_s1 * s_s1));
			ys_s2 <= rnd(64'(uy_s1 * s_s1));
			zs_s2 <= rnd(64'(uz_s1 * s_s1));
		end
	end

	// stage 3: sums and saturation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (ctl.enable) out_valid <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (ctl.enable) begin
			mat <= {sat(48'(zz_s2) + dz_s2), sat(tyz_s2 + xs_s2), sat(tzx_s2 - ys_s2),
				sat(tyz_s2 - xs_s2), sat(48'(yy_s2) + dy_s2), sat(txy_s2 + zs_s2),
				sat(tzx_s2 + ys_s2), sat(txy_s2 - zs_s2), sat(48'(xx_s2) + dx_s2)};
		end
	end
endmodule
